[rtl/aldm_pkg.sv]
// ----------------------------------------------------------------------------
// aldm_pkg
// Shared types and constants for the audio loudness duration monitor.
// ----------------------------------------------------------------------------
package aldm_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned THR_W    = 16;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd2500;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
    logic [TIME_W-1:0]          time_ms;
  } aldm_in_t;

  typedef struct packed {
    logic              is_loud;
    logic [TIME_W-1:0] loud_total_ms;
  } aldm_out_t;

endpackage

[rtl/audio_loudness_duration_monitor.sv]
// ----------------------------------------------------------------------------
// audio_loudness_duration_monitor
// Mean absolute level detector over sample blocks with loud-time accounting.
// ----------------------------------------------------------------------------
//  channel   ports                          direction  transfer when
//  input     in_valid/in_ready/in_data      in         in_valid && in_ready
//  result    out_valid/out_ready/out_data   out        out_valid && out_ready
//  config    cfg_we/cfg_wdata               in         cfg_we
//
//  One sample per cycle while in_ready is high; a closing sample's result
//  reaches out_valid through the accumulate, bound multiply and loudness
//  update registers, in that order.
//  Samples that do not close a block produce no result.
//  Each stage moves when the stage after it is empty or being drained, so a
//  stalled result holds the pipe only once all three registers are full.
//  Synchronous reset clears block sums, loud state, the total and the
//  threshold (to 2500).
// ----------------------------------------------------------------------------
module audio_loudness_duration_monitor #(
  parameter int unsigned MAX_BLOCK = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  aldm_pkg::aldm_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output aldm_pkg::aldm_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [aldm_pkg::THR_W-1:0]      cfg_wdata
);
  import aldm_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + CNT_W;
  localparam int unsigned PROD_W = THR_W + 1 + CNT_W;

  logic [THR_W-1:0]  threshold_r, threshold_nxt;

  logic              cls_valid, cls_ready;
  logic [SUM_W-1:0]  cls_sum;
  logic [CNT_W-1:0]  cls_cnt;
  logic [TIME_W-1:0] cls_time;

  logic              scl_valid, scl_ready;
  logic [SUM_W-1:0]  scl_sum;
  logic [PROD_W-1:0] scl_bound;
  logic [TIME_W-1:0] scl_time;

  assign threshold_nxt = cfg_we ? cfg_wdata : threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else begin
      threshold_r <= threshold_nxt;
    end
  end

  aldm_accum #(
    .MAX_BLOCK (MAX_BLOCK),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_sum   (cls_sum),
    .cls_cnt   (cls_cnt),
    .cls_time  (cls_time)
  );

  aldm_scale #(
    .CNT_W  (CNT_W),
    .SUM_W  (SUM_W),
    .PROD_W (PROD_W)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (threshold_r),
    .up_valid  (cls_valid),
    .up_ready  (cls_ready),
    .up_sum    (cls_sum),
    .up_cnt    (cls_cnt),
    .up_time   (cls_time),
    .dn_valid  (scl_valid),
    .dn_ready  (scl_ready),
    .dn_sum    (scl_sum),
    .dn_bound  (scl_bound),
    .dn_time   (scl_time)
  );

  aldm_track #(
    .SUM_W  (SUM_W),
    .PROD_W (PROD_W)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (scl_valid),
    .up_ready  (scl_ready),
    .up_sum    (scl_sum),
    .up_bound  (scl_bound),
    .up_time   (scl_time),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/aldm_accum.sv]
// ----------------------------------------------------------------------------
// aldm_accum
// Sums sample magnitudes over a block and emits the closed block's sum,
// sample count and closing time.
// ----------------------------------------------------------------------------
module aldm_accum #(
  parameter int unsigned MAX_BLOCK = 1024,
  parameter int unsigned CNT_W     = 11,
  parameter int unsigned SUM_W     = 27
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  aldm_pkg::aldm_in_t            in_data,
  output logic                          cls_valid,
  input  logic                          cls_ready,
  output logic [SUM_W-1:0]              cls_sum,
  output logic [CNT_W-1:0]              cls_cnt,
  output logic [aldm_pkg::TIME_W-1:0]   cls_time
);
  import aldm_pkg::*;

  logic [SUM_W-1:0]    level_sum_r, level_sum_nxt;
  logic [CNT_W-1:0]    block_count_r, block_count_nxt;
  logic                cls_valid_r, cls_valid_nxt;
  logic [SUM_W-1:0]    cls_sum_r;
  logic [CNT_W-1:0]    cls_cnt_r;
  logic [TIME_W-1:0]   cls_time_r;

  logic [SAMPLE_W-1:0] raw;
  logic [SAMPLE_W-1:0] mag;
  logic [SUM_W-1:0]    sum_inc;
  logic [CNT_W-1:0]    cnt_inc;
  logic                close;
  logic                in_xfer;

  assign in_ready = !cls_valid_r || cls_ready;
  assign in_xfer  = in_valid && in_ready;

  // most negative sample wraps to 0x8000, read unsigned as 32768
  assign raw     = in_data.sample;
  assign mag     = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
  assign sum_inc = level_sum_r + SUM_W'(mag);
  assign cnt_inc = block_count_r + 1'b1;
  assign close   = in_data.block_end || (cnt_inc == CNT_W'(MAX_BLOCK));

  always_comb begin
    level_sum_nxt   = level_sum_r;
    block_count_nxt = block_count_r;
    cls_valid_nxt   = cls_valid_r;
    if (in_xfer) begin
      cls_valid_nxt = close;
      if (close) begin
        level_sum_nxt   = '0;
        block_count_nxt = '0;
      end else begin
        level_sum_nxt   = sum_inc;
        block_count_nxt = cnt_inc;
      end
    end else if (cls_ready) begin
      cls_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_sum_r   <= '0;
      block_count_r <= '0;
      cls_valid_r   <= 1'b0;
    end else begin
      level_sum_r   <= level_sum_nxt;
      block_count_r <= block_count_nxt;
      cls_valid_r   <= cls_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && close) begin
      cls_sum_r  <= sum_inc;
      cls_cnt_r  <= cnt_inc;
      cls_time_r <= in_data.time_ms;
    end
  end

  assign cls_valid = cls_valid_r;
  assign cls_sum   = cls_sum_r;
  assign cls_cnt   = cls_cnt_r;
  assign cls_time  = cls_time_r;

endmodule

[rtl/aldm_scale.sv]
// ----------------------------------------------------------------------------
// aldm_scale
// Forms the loudness bound (threshold + 1) * count for a closed block.
// ----------------------------------------------------------------------------
module aldm_scale #(
  parameter int unsigned CNT_W  = 11,
  parameter int unsigned SUM_W  = 27,
  parameter int unsigned PROD_W = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [aldm_pkg::THR_W-1:0]    threshold,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [SUM_W-1:0]              up_sum,
  input  logic [CNT_W-1:0]              up_cnt,
  input  logic [aldm_pkg::TIME_W-1:0]   up_time,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [SUM_W-1:0]              dn_sum,
  output logic [PROD_W-1:0]             dn_bound,
  output logic [aldm_pkg::TIME_W-1:0]   dn_time
);
  import aldm_pkg::*;

  logic                dn_valid_r, dn_valid_nxt;
  logic [SUM_W-1:0]    sum_r;
  logic [PROD_W-1:0]   bound_r;
  logic [TIME_W-1:0]   time_r;
  logic [THR_W:0]      thr_p1;
  logic [PROD_W-1:0]   bound;
  logic                up_xfer;

  assign up_ready = !dn_valid_r || dn_ready;
  assign up_xfer  = up_valid && up_ready;

  assign thr_p1 = {1'b0, threshold} + 1'b1;
  assign bound  = PROD_W'(thr_p1) * PROD_W'(up_cnt);

  always_comb begin
    dn_valid_nxt = dn_valid_r;
    if (up_xfer) begin
      dn_valid_nxt = 1'b1;
    end else if (dn_ready) begin
      dn_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_valid_r <= 1'b0;
    end else begin
      dn_valid_r <= dn_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_xfer) begin
      sum_r   <= up_sum;
      bound_r <= bound;
      time_r  <= up_time;
    end
  end

  assign dn_valid = dn_valid_r;
  assign dn_sum   = sum_r;
  assign dn_bound = bound_r;
  assign dn_time  = time_r;

endmodule

[rtl/aldm_track.sv]
// ----------------------------------------------------------------------------
// aldm_track
// Decides loudness per block, follows loud periods and keeps the running
// loud total; holds the result register.
// ----------------------------------------------------------------------------
module aldm_track #(
  parameter int unsigned SUM_W  = 27,
  parameter int unsigned PROD_W = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [SUM_W-1:0]              up_sum,
  input  logic [PROD_W-1:0]             up_bound,
  input  logic [aldm_pkg::TIME_W-1:0]   up_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output aldm_pkg::aldm_out_t           out_data
);
  import aldm_pkg::*;

  logic              loud_now_r, loud_now_nxt;
  logic [TIME_W-1:0] loud_since_r, loud_since_nxt;
  logic [TIME_W-1:0] loud_accum_r, loud_accum_nxt;
  logic              out_valid_r, out_valid_nxt;
  aldm_out_t         out_data_r;
  logic              loud;
  logic              up_xfer;

  assign up_ready = !out_valid_r || out_ready;
  assign up_xfer  = up_valid && up_ready;

  assign loud = PROD_W'(up_sum) >= up_bound;

  always_comb begin
    loud_now_nxt   = loud_now_r;
    loud_since_nxt = loud_since_r;
    loud_accum_nxt = loud_accum_r;
    out_valid_nxt  = out_valid_r;
    if (up_xfer) begin
      out_valid_nxt = 1'b1;
      if (loud && !loud_now_r) begin
        loud_now_nxt   = 1'b1;
        loud_since_nxt = up_time;
      end else if (!loud && loud_now_r) begin
        // elapsed time and total both wrap at 48 bits
        loud_now_nxt   = 1'b0;
        loud_since_nxt = '0;
        loud_accum_nxt = loud_accum_r + up_time - loud_since_r;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loud_now_r   <= 1'b0;
      loud_since_r <= '0;
      loud_accum_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      loud_now_r   <= loud_now_nxt;
      loud_since_r <= loud_since_nxt;
      loud_accum_r <= loud_accum_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_xfer) begin
      out_data_r.is_loud       <= loud;
      out_data_r.loud_total_ms <= loud_accum_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[bench/audio_loudness_duration_monitor_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_loudness_duration_monitor_test
// Self-checking bench for the loudness duration monitor. A queue of samples
// feeds a valid/ready driver; every accepted sample runs through a local
// block-level predictor, and each closed block's expected flag and loud total
// wait in order for the result monitor. Directed cases cover the level
// boundaries, time wrap and total wrap; random phases sweep the threshold
// (extremes included), one full count-limited block, random idling on both
// channels and a long result stall that backs up the input.
// ----------------------------------------------------------------------------
module audio_loudness_duration_monitor_test;
  import aldm_pkg::*;

  localparam int unsigned BLOCK_LIMIT   = 1024;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_AT       = 130;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned PHASE_ITEMS   = 75;
  localparam int unsigned TIMEOUT_NS    = 5_000_000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  aldm_in_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  aldm_out_t          out_data;
  logic               cfg_we = 1'b0;
  logic [THR_W-1:0]   cfg_wdata = '0;

  aldm_in_t           sample_q[$];
  aldm_out_t          loud_report_q[$];
  int unsigned        n_mismatch = 0;
  int unsigned        n_accepted = 0;
  bit                 idle_on = 1'b1;
  logic [TIME_W-1:0]  now_ms = 48'd3000;

  // Predictor state
  logic [THR_W-1:0]   thr_now = THRESHOLD_RESET;
  longint unsigned    blk_sum = 0;
  longint unsigned    blk_count = 0;
  bit                 loud_state = 1'b0;
  logic [TIME_W-1:0]  loud_start_ms = '0;
  logic [TIME_W-1:0]  run_total_ms = '0;

  int unsigned        in_gap = 0;
  int unsigned        out_gap = 0;
  int unsigned        hold_left = 0;
  bit                 hold_done = 1'b0;

  audio_loudness_duration_monitor #(
    .MAX_BLOCK(BLOCK_LIMIT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    n_mismatch++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Fold one sample into the open block; on close, update the loud period
  // bookkeeping and return the result the block should emit.
  function automatic void step_loudness(input aldm_in_t s, output bit closes,
                                        output aldm_out_t res);
    logic [16:0]     mag;
    longint unsigned bound;
    bit              loud;
    mag = s.sample[15] ? (17'h10000 - {1'b0, s.sample}) : {1'b0, s.sample};
    blk_sum = blk_sum + mag;
    blk_count = blk_count + 1;
    closes = s.block_end || (blk_count >= BLOCK_LIMIT);
    res = '0;
    if (!closes) return;
    bound = (longint'(thr_now) + 1) * blk_count;
    loud = (blk_sum >= bound);
    if (loud && !loud_state) begin
      loud_start_ms = s.time_ms;
      loud_state = 1'b1;
    end else if (!loud && loud_state) begin
      run_total_ms = run_total_ms + (s.time_ms - loud_start_ms);
      loud_start_ms = '0;
      loud_state = 1'b0;
    end
    blk_sum = 0;
    blk_count = 0;
    res.is_loud = loud;
    res.loud_total_ms = run_total_ms;
  endfunction

  function automatic void push_sample(input logic signed [SAMPLE_W-1:0] s,
                                      input logic e, input logic [TIME_W-1:0] t);
    aldm_in_t item;
    item.sample = s;
    item.block_end = e;
    item.time_ms = t;
    sample_q.push_back(item);
  endfunction

  task automatic write_threshold(input logic [THR_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_now = v;
  endtask

  // Sample from negedge so the driver's edge updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || loud_report_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Blocks lean below, around or above the threshold so both outcomes occur.
  task automatic queue_random_samples(input int unsigned count);
    int                       mag;
    int unsigned              lean;
    int unsigned              pick;
    logic signed [SAMPLE_W-1:0] smp;
    logic [63:0]              wide;
    bit                       closes;
    bit                       fresh;
    fresh = 1'b1;
    lean = 0;
    for (int unsigned k = 0; k < count; k++) begin
      if (fresh) lean = $urandom_range(0, 2);
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        wide = {$urandom, $urandom};
        smp = wide[15:0];
      end else if (pick == 1) begin
        case ($urandom_range(0, 3))
          0: smp = 16'sh8000;
          1: smp = 16'sh7FFF;
          2: smp = 16'sh0000;
          default: smp = 16'shFFFF;
        endcase
      end else begin
        mag = (thr_now > 16'd32768) ? 32768 : int'(thr_now);
        case (lean)
          0: mag = mag - int'($urandom_range(0, 3));
          1: mag = mag + int'($urandom_range(0, 2)) - 1;
          default: mag = mag + int'($urandom_range(0, 3));
        endcase
        if (mag < 0) mag = 0;
        if (mag > 32768) mag = 32768;
        smp = mag[15:0];
        if (mag != 32768 && $urandom_range(0, 1) == 1) smp = -smp;
      end
      pick = $urandom_range(0, 63);
      if (pick == 0) begin
        wide = {$urandom, $urandom};
        now_ms = wide[TIME_W-1:0];
      end else if (pick == 1) begin
        now_ms = now_ms - $urandom_range(1, 1000);
      end else begin
        now_ms = now_ms + $urandom_range(0, 40);
      end
      closes = ($urandom_range(0, 3) == 0);
      push_sample(smp, closes, now_ms);
      fresh = closes;
    end
  endtask

  task automatic run_random_phase(input logic [THR_W-1:0] thr, input bit idle);
    write_threshold(thr);
    idle_on = idle;
    queue_random_samples(PHASE_ITEMS);
    wait_idle();
  endtask

  always @(posedge clk) begin : drive_samples
    bit        closes;
    aldm_out_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        step_loudness(in_data, closes, res);
        if (closes) loud_report_q.push_back(res);
        n_accepted <= n_accepted + 1;
      end
      // Hold valid and payload until the transfer completes.
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_data <= sample_q.pop_front();
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    aldm_out_t   want;
    int unsigned n_results;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
      n_results = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (loud_report_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d with nothing expected: is_loud %b total %0d",
                                  n_results, out_data.is_loud, out_data.loud_total_ms));
        end else begin
          want = loud_report_q.pop_front();
          if (out_data.is_loud !== want.is_loud ||
              out_data.loud_total_ms !== want.loud_total_ms)
            flag_mismatch($sformatf("result %0d: is_loud %b exp %b, total %0d exp %0d",
                                    n_results, out_data.is_loud, want.is_loud,
                                    out_data.loud_total_ms, want.loud_total_ms));
        end
      end
      // Stall once for a long stretch so the pipe fills and backs up the input.
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 12);
      end
    end
  end

  initial begin : run_test
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset threshold: just above / at the level, loud and quiet repeats,
    // most negative sample, time running backwards, total wrapping.
    push_sample(16'sd2501, 1'b1, 48'd100);
    push_sample(-16'sd2501, 1'b1, 48'd150);
    push_sample(16'sd2500, 1'b1, 48'd400);
    push_sample(16'sd0, 1'b1, 48'd500);
    push_sample(16'sh8000, 1'b1, 48'd600);
    push_sample(16'sh7FFF, 1'b0, 48'd610);
    push_sample(16'sh8000, 1'b0, 48'd620);
    push_sample(16'sd0, 1'b1, 48'd10);
    push_sample(16'sd1, 1'b1, 48'd5);
    push_sample(16'sd3000, 1'b1, 48'd1000);
    push_sample(16'sd0, 1'b1, 48'd1500);
    push_sample(16'sd2501, 1'b0, 48'd1550);
    push_sample(16'sd2500, 1'b1, 48'd1600);
    push_sample(16'sd2501, 1'b0, 48'd1650);
    push_sample(-16'sd2501, 1'b1, 48'hFFFF_FFFF_FFFF);
    push_sample(-16'sd100, 1'b1, 48'd0);
    wait_idle();

    write_threshold(16'd0);
    push_sample(16'sd0, 1'b1, 48'd2000);
    push_sample(16'sd1, 1'b1, 48'd2100);
    push_sample(-16'sd1, 1'b1, 48'd2200);
    push_sample(16'sd0, 1'b1, 48'd2300);
    wait_idle();

    write_threshold(16'hFFFF);
    push_sample(16'sh8000, 1'b1, 48'd2400);
    wait_idle();

    run_random_phase(16'd32768, 1'b1);
    run_random_phase(16'd0, 1'b1);
    run_random_phase(16'd1000, 1'b0);
    run_random_phase(16'($urandom_range(0, 65535)), 1'b1);

    // Close any open block, then one unflagged block that ends on the count
    // limit with the sum exactly at the bound.
    write_threshold(16'd32767);
    idle_on = 1'b1;
    push_sample(16'sd0, 1'b1, now_ms);
    for (int unsigned k = 0; k < BLOCK_LIMIT; k++) begin
      now_ms = now_ms + 1;
      push_sample(16'sh8000, 1'b0, now_ms);
    end
    queue_random_samples(PHASE_ITEMS);
    wait_idle();

    run_random_phase(16'hFFFF, 1'b1);
    run_random_phase(16'($urandom_range(1, 32768)), 1'b1);
    run_random_phase(THRESHOLD_RESET, 1'b0);

    if (n_mismatch == 0 && loud_report_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[audio_loudness_duration_monitor.f]
rtl/aldm_pkg.sv
rtl/aldm_accum.sv
rtl/aldm_scale.sv
rtl/aldm_track.sv
rtl/audio_loudness_duration_monitor.sv
bench/audio_loudness_duration_monitor_test.sv
